>>> src/mbtcp_pkg.sv
`default_nettype none

package mbtcp_pkg;

    // sizes fixed by the field layout
    localparam int HDR_BYTES = 13;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 88;

    // parameter defaults
    localparam int DEF_TABLE_DEPTH     = 2048;
    localparam int DEF_MAX_FRAME_BYTES = 260;

    // configuration register indexes
    localparam logic CFG_OWN_UNIT_ID      = 1'b0;
    localparam logic CFG_REGISTERS_IN_USE = 1'b1;

    // configuration reset values
    localparam logic [7:0]  OWN_UNIT_ID_RST      = 8'd1;
    localparam logic [11:0] REGISTERS_IN_USE_RST = 12'd2000;

    // input selector codes
    localparam logic [1:0] FUNC_TABLE_WRITE = 2'd0;
    localparam logic [1:0] FUNC_TABLE_READ  = 2'd1;
    localparam logic [1:0] FUNC_FRAME_BYTE  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_HEADER     = 2'd0;
    localparam logic [1:0] KIND_DATA_PAIR  = 2'd1;
    localparam logic [1:0] KIND_HOST_READ  = 2'd2;

    // modbus function codes
    localparam logic [7:0] FC_READ_HOLDING = 8'd3;
    localparam logic [7:0] FC_READ_INPUT   = 8'd4;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'd6;
    localparam logic [7:0] FC_WRITE_MULTI  = 8'd16;

    // exception codes and limits
    localparam logic [15:0] EXC_ILLEGAL_FUNCTION = 16'd1;
    localparam logic [15:0] EXC_ILLEGAL_ADDRESS  = 16'd2;
    localparam logic [7:0]  EXC_BIT              = 8'h80;
    localparam logic [15:0] READ_MAX             = 16'd125;
    localparam logic [15:0] WRITE_MAX            = 16'd123;

    // controller states
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_HREAD = 6'b000100,
        S_EVAL  = 6'b001000,
        S_RDA   = 6'b010000,
        S_PAIR  = 6'b100000
    } state_t;

endpackage

`default_nettype wire

>>> src/modbus_tcp_request_responder_top.sv
// order: host table read answers come from S_HREAD; a request frame gives its header
//   result from S_EVAL after its last byte, data pairs follow via S_RDA then S_PAIR
// throughput: one word a cycle for host writes and frame bytes while idle; host reads
//   wait in S_HREAD; a read request streams ceil(count/2) pairs on one table memory read port
// reset: after aresetn the table is cleared one word a cycle, with
//   s_tready low; configuration writes are taken throughout
`default_nettype none

module modbus_tcp_request_responder_top
    import mbtcp_pkg::*;
#(
    parameter int TABLE_DEPTH     = DEF_TABLE_DEPTH,
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // configuration
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [11:0]         cfg_wdata,
    // request side
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // table_address[10:0], table_value[26:11], frame_byte[34:27], zero fill
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // func[1:0]
    input  wire logic [1:0]          s_tuser,
    input  wire logic                s_tlast,
    // result side
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // transaction_id[15:0], length_field[31:16], unit_out[39:32], function_out[47:40],
    // word_a[63:48], word_b[79:64], words_valid[81:80], zero fill
    output logic [M_DATA_W-1:0]      m_tdata,
    // kind[1:0]
    output logic [1:0]               m_tuser,
    output logic                     m_tlast
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [16:0]   DEPTH17  = 17'(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
    localparam logic [8:0]    MAX_LEN  = 9'(MAX_FRAME_BYTES);

    // table memory
    logic [15:0]   mem [TABLE_DEPTH];
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rd_q;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q <= mem[rd_addr];
        end
    end

    // control and payload registers
    state_t        state_reg, state_next;
    logic [AW-1:0] clr_ptr_reg, clr_ptr_next;
    logic [7:0]    own_id_reg;
    logic [11:0]   riu_reg;
    logic [7:0]    hdr_reg [HDR_BYTES];
    logic [7:0]    hdr_next [HDR_BYTES];
    logic [8:0]    len_reg, len_next;
    logic          ovf_reg, ovf_next;
    logic          hit_reg, hit_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [6:0]    rem_reg, rem_next;
    logic [15:0]   hold_reg, hold_next;

    logic          m_valid_reg, m_valid_next;
    logic [1:0]    m_kind_reg, m_kind_next;
    logic [15:0]   m_tid_reg, m_tid_next;
    logic [15:0]   m_len_reg, m_len_next;
    logic [7:0]    m_unit_reg, m_unit_next;
    logic [7:0]    m_fn_reg, m_fn_next;
    logic [15:0]   m_a_reg, m_a_next;
    logic [15:0]   m_b_reg, m_b_next;
    logic [1:0]    m_wv_reg, m_wv_next;
    logic          m_last_reg, m_last_next;

    // input word fields
    logic [10:0] in_addr;
    logic [15:0] in_value;
    logic [7:0]  in_byte;
    logic        s_accept;
    logic        out_free;

    assign in_addr  = s_tdata[10:0];
    assign in_value = s_tdata[26:11];
    assign in_byte  = s_tdata[34:27];
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // effective word limit and host address check
    logic [16:0]   lim;
    logic [16:0]   host_addr17;
    logic          host_hit;
    logic [AW-1:0] host_idx;

    assign lim         = ({5'd0, riu_reg} < DEPTH17) ? {5'd0, riu_reg} : DEPTH17;
    assign host_addr17 = {6'd0, in_addr};
    assign host_hit    = host_addr17 < lim;
    assign host_idx    = host_addr17[AW-1:0];

    // request header decode
    logic [15:0] h_tid, h_proto, h_mlen, h_addr, h_cnt;
    logic [7:0]  h_unit, h_fn, h_bc;
    logic [17:0] addr_end;
    logic        hdr_ok, range_bad;

    assign h_tid    = {hdr_reg[0], hdr_reg[1]};
    assign h_proto  = {hdr_reg[2], hdr_reg[3]};
    assign h_mlen   = {hdr_reg[4], hdr_reg[5]};
    assign h_unit   = hdr_reg[6];
    assign h_fn     = hdr_reg[7];
    assign h_addr   = {hdr_reg[8], hdr_reg[9]};
    assign h_cnt    = {hdr_reg[10], hdr_reg[11]};
    assign h_bc     = hdr_reg[12];
    assign addr_end = {2'd0, h_addr} + {2'd0, h_cnt};

    assign hdr_ok = !ovf_reg && (len_reg >= 9'd8) && (len_reg <= MAX_LEN)
                    && (h_proto == 16'd0) && (h_mlen == (16'(len_reg) - 16'd6))
                    && (h_unit == own_id_reg);

    assign range_bad = ({1'b0, h_addr} >= lim) || (addr_end > {1'b0, lim})
                       || (h_cnt == 16'd0);

    // response selection
    logic        resp_drop, resp_exc, resp_data;
    logic [15:0] resp_len, resp_a, resp_b, resp_exc_code;
    logic [1:0]  resp_wv;

    always_comb begin
        resp_drop     = !hdr_ok;
        resp_exc      = 1'b0;
        resp_exc_code = EXC_ILLEGAL_ADDRESS;
        resp_data     = 1'b0;
        resp_len      = 16'd6;
        resp_a        = h_addr;
        resp_b        = h_cnt;
        resp_wv       = 2'd2;
        if (h_fn == FC_READ_HOLDING || h_fn == FC_READ_INPUT) begin
            if (len_reg < 9'd12) begin
                resp_drop = 1'b1;
            end
            resp_exc  = range_bad || (h_cnt > READ_MAX);
            resp_data = !resp_exc;
            resp_len  = 16'd3 + {h_cnt[14:0], 1'b0};
            resp_a    = {h_cnt[14:0], 1'b0};
            resp_b    = 16'd0;
            resp_wv   = 2'd1;
        end else if (h_fn == FC_WRITE_SINGLE) begin
            if (len_reg < 9'd12) begin
                resp_drop = 1'b1;
            end
            resp_exc = {1'b0, h_addr} >= lim;
        end else if (h_fn == FC_WRITE_MULTI) begin
            if (len_reg < 9'(HDR_BYTES)) begin
                resp_drop = 1'b1;
            end
            resp_exc = range_bad || (h_cnt > WRITE_MAX)
                       || ({9'd0, h_bc} != {h_cnt, 1'b0})
                       || ({1'b0, len_reg} < (10'(HDR_BYTES) + {2'd0, h_bc}));
        end else begin
            resp_exc      = 1'b1;
            resp_exc_code = EXC_ILLEGAL_FUNCTION;
        end
    end

    // controller
    always_comb begin
        state_next   = state_reg;
        clr_ptr_next = clr_ptr_reg;
        hdr_next     = hdr_reg;
        len_next     = len_reg;
        ovf_next     = ovf_reg;
        hit_next     = hit_reg;
        ptr_next     = ptr_reg;
        rem_next     = rem_reg;
        hold_next    = hold_reg;

        m_valid_next = m_valid_reg;
        m_kind_next  = m_kind_reg;
        m_tid_next   = m_tid_reg;
        m_len_next   = m_len_reg;
        m_unit_next  = m_unit_reg;
        m_fn_next    = m_fn_reg;
        m_a_next     = m_a_reg;
        m_b_next     = m_b_reg;
        m_wv_next    = m_wv_reg;
        m_last_next  = m_last_reg;

        wr_en   = 1'b0;
        wr_addr = clr_ptr_reg;
        wr_data = 16'd0;
        rd_en   = 1'b0;
        rd_addr = ptr_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            // clearing pass over the table after reset
            S_CLEAR: begin
                wr_en = 1'b1;
                if (clr_ptr_reg == LAST_IDX) begin
                    state_next = S_IDLE;
                end else begin
                    clr_ptr_next = clr_ptr_reg + AW'(1);
                end
            end

            S_IDLE: begin
                if (s_accept) begin
                    case (s_tuser)
                        FUNC_TABLE_WRITE: begin
                            wr_en   = host_hit;
                            wr_addr = host_idx;
                            wr_data = in_value;
                        end
                        FUNC_TABLE_READ: begin
                            hit_next   = host_hit;
                            rd_en      = host_hit;
                            rd_addr    = host_idx;
                            state_next = S_HREAD;
                        end
                        FUNC_FRAME_BYTE: begin
                            if (len_reg < MAX_LEN) begin
                                if (len_reg < 9'(HDR_BYTES)) begin
                                    hdr_next[len_reg[3:0]] = in_byte;
                                end
                                len_next = len_reg + 9'd1;
                            end else begin
                                ovf_next = 1'b1;
                            end
                            if (s_tlast) begin
                                state_next = S_EVAL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // host read answer
            S_HREAD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_HOST_READ;
                    m_tid_next   = 16'd0;
                    m_len_next   = 16'd0;
                    m_unit_next  = 8'd0;
                    m_fn_next    = 8'd0;
                    m_a_next     = hit_reg ? rd_q : 16'd0;
                    m_b_next     = 16'd0;
                    m_wv_next    = hit_reg ? 2'd1 : 2'd0;
                    m_last_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            // frame check and response header
            S_EVAL: begin
                if (resp_drop) begin
                    len_next   = 9'd0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end else if (out_free) begin
                    len_next     = 9'd0;
                    ovf_next     = 1'b0;
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_HEADER;
                    m_tid_next   = h_tid;
                    m_unit_next  = own_id_reg;
                    m_b_next     = 16'd0;
                    m_wv_next    = 2'd1;
                    m_last_next  = !resp_data;
                    if (resp_exc) begin
                        m_len_next = 16'd3;
                        m_fn_next  = h_fn | EXC_BIT;
                        m_a_next   = resp_exc_code;
                    end else begin
                        m_len_next = resp_len;
                        m_fn_next  = h_fn;
                        m_a_next   = resp_a;
                        m_b_next   = resp_b;
                        m_wv_next  = resp_wv;
                    end
                    if (resp_data) begin
                        ptr_next   = h_addr[AW-1:0];
                        rem_next   = h_cnt[6:0];
                        rd_en      = 1'b1;
                        rd_addr    = h_addr[AW-1:0];
                        state_next = S_RDA;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end

            // first word of a pair arrives, fetch the second
            S_RDA: begin
                hold_next = rd_q;
                if (rem_reg > 7'd1) begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_reg + AW'(1);
                end
                state_next = S_PAIR;
            end

            // send the pair and move on
            S_PAIR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_DATA_PAIR;
                    m_tid_next   = 16'd0;
                    m_len_next   = 16'd0;
                    m_unit_next  = 8'd0;
                    m_fn_next    = 8'd0;
                    m_a_next     = hold_reg;
                    m_b_next     = (rem_reg > 7'd1) ? rd_q : 16'd0;
                    m_wv_next    = (rem_reg > 7'd1) ? 2'd2 : 2'd1;
                    m_last_next  = rem_reg <= 7'd2;
                    if (rem_reg > 7'd2) begin
                        rem_next   = rem_reg - 7'd2;
                        ptr_next   = ptr_reg + AW'(2);
                        rd_en      = 1'b1;
                        rd_addr    = ptr_reg + AW'(2);
                        state_next = S_RDA;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_ptr_reg <= '0;
            len_reg     <= 9'd0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            own_id_reg  <= OWN_UNIT_ID_RST;
            riu_reg     <= REGISTERS_IN_USE_RST;
        end else begin
            state_reg   <= state_next;
            clr_ptr_reg <= clr_ptr_next;
            len_reg     <= len_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                if (cfg_index == CFG_OWN_UNIT_ID) begin
                    own_id_reg <= cfg_wdata[7:0];
                end
                if (cfg_index == CFG_REGISTERS_IN_USE) begin
                    riu_reg <= cfg_wdata;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        hdr_reg    <= hdr_next;
        hit_reg    <= hit_next;
        ptr_reg    <= ptr_next;
        rem_reg    <= rem_next;
        hold_reg   <= hold_next;
        m_kind_reg <= m_kind_next;
        m_tid_reg  <= m_tid_next;
        m_len_reg  <= m_len_next;
        m_unit_reg <= m_unit_next;
        m_fn_reg   <= m_fn_next;
        m_a_reg    <= m_a_next;
        m_b_reg    <= m_b_next;
        m_wv_reg   <= m_wv_next;
        m_last_reg <= m_last_next;
    end

    // result word packing
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {6'd0, m_wv_reg, m_b_reg, m_a_reg, m_fn_reg, m_unit_reg,
                       m_len_reg, m_tid_reg};

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mbtcp_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 500000;

    // one expected result word
    typedef struct {
        logic [1:0]  kind;
        logic [15:0] tid;
        logic [15:0] mbap_len;
        logic [7:0]  unit;
        logic [7:0]  fn;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [1:0]  valid;
        logic        last;
    } reply_t;

    // responder model: table, header capture, frame count and expected replies
    class modbus_scoreboard;
        logic [15:0] words_mem [DEF_TABLE_DEPTH];
        logic [7:0]  hdr_bytes [HDR_BYTES];
        int unsigned frame_len;
        bit          frame_ovf;
        logic [7:0]  unit_id;
        logic [11:0] regs_in_use;
        reply_t      pending [$];
        int unsigned mismatches;
        int unsigned items_taken;
        int unsigned replies_made;
        int unsigned replies_checked;

        function new();
            foreach (words_mem[i]) words_mem[i] = '0;
            foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
            frame_len = 0;
            frame_ovf = 1'b0;
            unit_id = OWN_UNIT_ID_RST;
            regs_in_use = REGISTERS_IN_USE_RST;
            mismatches = 0;
            items_taken = 0;
            replies_made = 0;
            replies_checked = 0;
        endfunction

        function void set_config(logic idx, logic [11:0] value);
            if (idx == CFG_OWN_UNIT_ID) begin
                unit_id = value[7:0];
            end else begin
                regs_in_use = value;
            end
        endfunction

        function int unsigned addressable_words();
            return (regs_in_use < DEF_TABLE_DEPTH) ? regs_in_use : DEF_TABLE_DEPTH;
        endfunction

        function void push_reply(logic [1:0] kind, logic [15:0] tid, logic [15:0] mbap_len,
                                 logic [7:0] unit, logic [7:0] fn, logic [15:0] word_a,
                                 logic [15:0] word_b, logic [1:0] valid);
            reply_t r;
            r.kind = kind;
            r.tid = tid;
            r.mbap_len = mbap_len;
            r.unit = unit;
            r.fn = fn;
            r.word_a = word_a;
            r.word_b = word_b;
            r.valid = valid;
            r.last = 1'b0;
            pending.push_back(r);
            replies_made++;
        endfunction

        // header checks and the reply of a complete request frame
        function void answer_frame();
            int unsigned lim, addr, cnt, bc, i;
            logic [15:0] tid;
            logic [7:0]  fn;
            lim = addressable_words();
            if (frame_ovf || frame_len < 8 || frame_len > DEF_MAX_FRAME_BYTES) return;
            if ({hdr_bytes[2], hdr_bytes[3]} != 16'd0) return;
            if ({hdr_bytes[4], hdr_bytes[5]} != frame_len - 6) return;
            if (hdr_bytes[6] != unit_id) return;
            tid = {hdr_bytes[0], hdr_bytes[1]};
            fn = hdr_bytes[7];
            if (fn == FC_READ_HOLDING || fn == FC_READ_INPUT) begin
                if (frame_len < 12) return;
                addr = {hdr_bytes[8], hdr_bytes[9]};
                cnt = {hdr_bytes[10], hdr_bytes[11]};
                if (addr >= lim || addr + cnt > lim || cnt == 0 || cnt > READ_MAX) begin
                    push_reply(KIND_HEADER, tid, 16'd3, unit_id, fn | EXC_BIT,
                               EXC_ILLEGAL_ADDRESS, 16'd0, 2'd1);
                end else begin
                    push_reply(KIND_HEADER, tid, 16'(3 + 2 * cnt), unit_id, fn,
                               16'(2 * cnt), 16'd0, 2'd1);
                    for (i = 0; i < cnt; i += 2) begin
                        if (i + 1 < cnt) begin
                            push_reply(KIND_DATA_PAIR, 16'd0, 16'd0, 8'd0, 8'd0,
                                       words_mem[addr + i], words_mem[addr + i + 1], 2'd2);
                        end else begin
                            push_reply(KIND_DATA_PAIR, 16'd0, 16'd0, 8'd0, 8'd0,
                                       words_mem[addr + i], 16'd0, 2'd1);
                        end
                    end
                end
            end else if (fn == FC_WRITE_SINGLE) begin
                if (frame_len < 12) return;
                addr = {hdr_bytes[8], hdr_bytes[9]};
                if (addr >= lim) begin
                    push_reply(KIND_HEADER, tid, 16'd3, unit_id, fn | EXC_BIT,
                               EXC_ILLEGAL_ADDRESS, 16'd0, 2'd1);
                end else begin
                    push_reply(KIND_HEADER, tid, 16'd6, unit_id, fn, 16'(addr),
                               {hdr_bytes[10], hdr_bytes[11]}, 2'd2);
                end
            end else if (fn == FC_WRITE_MULTI) begin
                if (frame_len < 13) return;
                addr = {hdr_bytes[8], hdr_bytes[9]};
                cnt = {hdr_bytes[10], hdr_bytes[11]};
                bc = hdr_bytes[12];
                if (addr >= lim || addr + cnt > lim || cnt == 0 || cnt > WRITE_MAX ||
                    bc != cnt * 2 || frame_len < 13 + bc) begin
                    push_reply(KIND_HEADER, tid, 16'd3, unit_id, fn | EXC_BIT,
                               EXC_ILLEGAL_ADDRESS, 16'd0, 2'd1);
                end else begin
                    push_reply(KIND_HEADER, tid, 16'd6, unit_id, fn, 16'(addr), 16'(cnt), 2'd2);
                end
            end else begin
                push_reply(KIND_HEADER, tid, 16'd3, unit_id, fn | EXC_BIT,
                           EXC_ILLEGAL_FUNCTION, 16'd0, 2'd1);
            end
        endfunction

        // one accepted input word
        function void note_word(logic [1:0] func, logic [10:0] addr, logic [15:0] val,
                                logic [7:0] fbyte, logic flast);
            int unsigned n_prior;
            n_prior = pending.size();
            case (func)
                FUNC_TABLE_WRITE: begin
                    items_taken++;
                    if (addr < addressable_words()) words_mem[addr] = val;
                end
                FUNC_TABLE_READ: begin
                    items_taken++;
                    if (addr < addressable_words()) begin
                        push_reply(KIND_HOST_READ, 16'd0, 16'd0, 8'd0, 8'd0,
                                   words_mem[addr], 16'd0, 2'd1);
                    end else begin
                        push_reply(KIND_HOST_READ, 16'd0, 16'd0, 8'd0, 8'd0,
                                   16'd0, 16'd0, 2'd0);
                    end
                end
                FUNC_FRAME_BYTE: begin
                    items_taken++;
                    if (frame_len < DEF_MAX_FRAME_BYTES) begin
                        if (frame_len < HDR_BYTES) hdr_bytes[frame_len] = fbyte;
                        frame_len++;
                    end else begin
                        frame_ovf = 1'b1;
                    end
                    if (flast) begin
                        answer_frame();
                        frame_len = 0;
                        frame_ovf = 1'b0;
                    end
                end
                default: ;
            endcase
            if (pending.size() > n_prior) pending[pending.size() - 1].last = 1'b1;
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 40) $display("mismatch: %s", what);
        endtask

        task check_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want) begin
                report($sformatf("result %0d %s got %h want %h", replies_checked, name,
                                 got, want));
            end
        endtask

        // one accepted result word against the oldest expectation
        task check_result(logic [1:0] kind, logic [M_DATA_W-1:0] data, logic last);
            reply_t want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result kind %0d data %h", kind, data));
                return;
            end
            want = pending.pop_front();
            replies_checked++;
            check_field("kind", kind, want.kind);
            check_field("transaction_id", data[15:0], want.tid);
            check_field("length_field", data[31:16], want.mbap_len);
            check_field("unit_out", data[39:32], want.unit);
            check_field("function_out", data[47:40], want.fn);
            check_field("word_a", data[63:48], want.word_a);
            check_field("word_b", data[79:64], want.word_b);
            check_field("words_valid", data[81:80], want.valid);
            check_field("last", last, want.last);
        endtask
    endclass

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic                cfg_index;
    logic [11:0]         cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [1:0]          s_tuser;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [1:0]          m_tuser;
    logic                m_tlast;

    modbus_scoreboard sb = new();
    bit               quiet;
    int unsigned      cycle_count;
    int unsigned      settings_done;
    logic [7:0]       frame_q [$];

    modbus_tcp_request_responder_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // result side stalls
    always @(posedge aclk) begin
        m_tready <= quiet || ($urandom_range(99) >= 26);
    end

    // result monitor
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
    end

    // drive one word and wait for its handshake
    task automatic send_word(input logic [1:0] func, input logic [10:0] addr,
                             input logic [15:0] val, input logic [7:0] fbyte,
                             input logic flast);
        if (!quiet) begin
            while ($urandom_range(99) < 26) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {{(S_DATA_W - 35){1'b0}}, fbyte, val, addr};
        s_tlast <= flast;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(func, addr, val, fbyte, flast);
    endtask

    task automatic host_word(input logic [1:0] func, input logic [10:0] addr,
                             input logic [15:0] val);
        send_word(func, addr, val, $urandom_range(255), $urandom_range(1));
    endtask

    // address mostly near the low end or the limit, sometimes anywhere
    function automatic logic [15:0] pick_address();
        int unsigned lim, lo, r;
        lim = sb.addressable_words();
        r = $urandom_range(99);
        if (r < 55) return $urandom_range((lim > 64) ? 63 : ((lim == 0) ? 7 : lim - 1));
        if (r < 75) begin
            lo = (lim > 4) ? lim - 4 : 0;
            return $urandom_range(lim + 3, lo);
        end
        if (r < 95) return $urandom_range(2047);
        return $urandom_range(65535);
    endfunction

    task automatic host_access(input bit write_op);
        logic [15:0] a;
        a = pick_address();
        host_word(write_op ? FUNC_TABLE_WRITE : FUNC_TABLE_READ, a[10:0], $urandom_range(65535));
    endtask

    // request frame assembly
    task automatic begin_frame(input logic [7:0] unit, input logic [7:0] fn);
        logic [15:0] tid;
        tid = $urandom_range(65535);
        frame_q = {tid[15:8], tid[7:0], 8'h00, 8'h00, 8'h00, 8'h00, unit, fn};
    endtask

    task automatic put16(input logic [15:0] v);
        frame_q.push_back(v[15:8]);
        frame_q.push_back(v[7:0]);
    endtask

    task automatic seal_length();
        logic [15:0] n;
        n = frame_q.size() - 6;
        frame_q[4] = n[15:8];
        frame_q[5] = n[7:0];
    endtask

    task automatic build_request(input logic [7:0] unit, input logic [7:0] fn,
                                 input logic [15:0] addr, input logic [15:0] w2,
                                 input int unsigned data_words, input logic [7:0] bc_skew);
        logic [7:0] bc;
        begin_frame(unit, fn);
        put16(addr);
        put16(w2);
        if (fn == FC_WRITE_MULTI) begin
            bc = 8'(2 * w2) + bc_skew;
            frame_q.push_back(bc);
            repeat (2 * data_words) frame_q.push_back($urandom_range(255));
        end
        seal_length();
    endtask

    // frame bytes, with host words slipped in between when asked
    task automatic send_frame(input bit mix_host);
        int unsigned i, last_i;
        last_i = frame_q.size() - 1;
        for (i = 0; i <= last_i; i++) begin
            if (mix_host && $urandom_range(24) == 0) host_access($urandom_range(1));
            send_word(FUNC_FRAME_BYTE, $urandom_range(2047), $urandom_range(65535),
                      frame_q[i], i == last_i);
        end
    endtask

    task automatic request(input logic [7:0] fn, input logic [15:0] addr,
                           input logic [15:0] w2, input int unsigned data_words,
                           input logic [7:0] bc_skew);
        build_request(sb.unit_id, fn, addr, w2, data_words, bc_skew);
        send_frame(1'b0);
    endtask

    // random request: mostly well formed, some broken
    task automatic random_request();
        logic [7:0]  unit, fn;
        logic [15:0] addr, w2;
        int unsigned r, dw, n;
        logic [7:0]  skew;
        unit = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : sb.unit_id;
        addr = pick_address();
        r = $urandom_range(99);
        if (r < 40) begin
            fn = $urandom_range(1) ? FC_READ_HOLDING : FC_READ_INPUT;
        end else if (r < 60) begin
            fn = FC_WRITE_SINGLE;
        end else if (r < 82) begin
            fn = FC_WRITE_MULTI;
        end else begin
            do fn = $urandom_range(255);
            while (fn == FC_READ_HOLDING || fn == FC_READ_INPUT ||
                   fn == FC_WRITE_SINGLE || fn == FC_WRITE_MULTI);
        end
        r = $urandom_range(99);
        if (fn == FC_WRITE_MULTI) begin
            if (r < 80) w2 = $urandom_range(6, 1);
            else if (r < 90) w2 = $urandom_range(1) ? 16'd0 : 16'($urandom_range(65535, 124));
            else w2 = $urandom_range(123, 7);
        end else if (fn == FC_WRITE_SINGLE) begin
            w2 = $urandom_range(65535);
        end else begin
            if (r < 70) w2 = $urandom_range(8, 1);
            else if (r < 85) w2 = $urandom_range(125, 1);
            else if (r < 92) w2 = 16'd0;
            else w2 = $urandom_range(65535, 126);
        end
        dw = (w2 <= WRITE_MAX) ? w2 : $urandom_range(4);
        if (dw > 0 && $urandom_range(9) == 0) dw--;
        skew = ($urandom_range(9) == 0) ? 8'd1 : 8'd0;
        build_request(unit, fn, addr, w2, dw, skew);
        if ($urandom_range(99) < 15) begin
            case ($urandom_range(3))
                0: frame_q[2 + $urandom_range(1)] = 8'(1 << $urandom_range(7));
                1: frame_q[5] = frame_q[5] ^ 8'(1 << $urandom_range(7));
                2: begin
                    n = $urandom_range(11, 1);
                    while (frame_q.size() > n) frame_q.pop_back();
                    if (n >= 6 && $urandom_range(1)) seal_length();
                end
                default: repeat ($urandom_range(4, 1)) frame_q.push_back($urandom_range(255));
            endcase
        end
        send_frame(1'b1);
    endtask

    task automatic random_op();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30) begin
            host_access(1'b1);
        end else if (r < 45) begin
            host_access(1'b0);
        end else if (r < 48) begin
            send_word(FUNC_UNUSED, $urandom_range(2047), $urandom_range(65535),
                      $urandom_range(255), $urandom_range(1));
        end else begin
            random_request();
        end
    endtask

    // let every reply drain before touching the registers or ending
    task automatic wait_idle(input int unsigned tail);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    task automatic set_registers(input logic [7:0] unit, input logic [11:0] regs);
        cfg_we <= 1'b1;
        cfg_index <= CFG_OWN_UNIT_ID;
        cfg_wdata <= {4'd0, unit};
        @(posedge aclk);
        sb.set_config(CFG_OWN_UNIT_ID, {4'd0, unit});
        cfg_index <= CFG_REGISTERS_IN_USE;
        cfg_wdata <= regs;
        @(posedge aclk);
        sb.set_config(CFG_REGISTERS_IN_USE, regs);
        cfg_we <= 1'b0;
        settings_done++;
    endtask

    task automatic run_phase(input logic [7:0] unit, input logic [11:0] regs,
                             input int unsigned budget, input bit no_idle);
        int unsigned start;
        wait_idle(8);
        set_registers(unit, regs);
        quiet = no_idle;
        start = sb.items_taken;
        while (sb.items_taken - start < budget) random_op();
    endtask

    initial begin
        int unsigned i;
        quiet = 1'b0;
        cycle_count = 0;
        settings_done = 0;
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_OWN_UNIT_ID;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= FUNC_TABLE_WRITE;
        s_tlast <= 1'b0;
        m_tready <= 1'b1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // host access at both ends of the range, reset settings
        host_word(FUNC_TABLE_WRITE, 11'd0, 16'hFFFF);
        host_word(FUNC_TABLE_WRITE, 11'd1999, 16'h8001);
        host_word(FUNC_TABLE_WRITE, 11'd2000, 16'h1234);
        host_word(FUNC_TABLE_WRITE, 11'd2047, 16'hAAAA);
        host_word(FUNC_TABLE_READ, 11'd0, 16'h0000);
        host_word(FUNC_TABLE_READ, 11'd1999, 16'hFFFF);
        host_word(FUNC_TABLE_READ, 11'd2000, 16'h0000);
        host_word(FUNC_TABLE_READ, 11'd2047, 16'h0000);
        send_word(FUNC_UNUSED, 11'h7FF, 16'hFFFF, 8'hFF, 1'b1);
        for (i = 1; i <= 6; i++) host_word(FUNC_TABLE_WRITE, 11'(i), $urandom_range(65535));
        host_word(FUNC_TABLE_WRITE, 11'd1998, $urandom_range(65535));

        // reads: odd and even counts, top of range, count limits
        request(FC_READ_HOLDING, 16'd0, 16'd5, 0, 8'd0);
        request(FC_READ_INPUT, 16'd1998, 16'd2, 0, 8'd0);
        request(FC_READ_HOLDING, 16'd1999, 16'd1, 0, 8'd0);
        request(FC_READ_INPUT, 16'd0, 16'd125, 0, 8'd0);
        request(FC_READ_HOLDING, 16'd0, 16'd126, 0, 8'd0);
        request(FC_READ_HOLDING, 16'd5, 16'd0, 0, 8'd0);
        request(FC_READ_INPUT, 16'd2000, 16'd1, 0, 8'd0);
        request(FC_READ_HOLDING, 16'd1999, 16'd2, 0, 8'd0);
        request(FC_READ_HOLDING, 16'hFFFF, 16'hFFFF, 0, 8'd0);

        // writes: echo, ack, byte count and range faults
        request(FC_WRITE_SINGLE, 16'd5, 16'hBEEF, 0, 8'd0);
        request(FC_WRITE_SINGLE, 16'd2000, 16'h0000, 0, 8'd0);
        request(FC_WRITE_MULTI, 16'd10, 16'd2, 2, 8'd0);
        request(FC_WRITE_MULTI, 16'd0, 16'd123, 123, 8'd0);
        request(FC_WRITE_MULTI, 16'd10, 16'd2, 2, 8'd1);
        request(FC_WRITE_MULTI, 16'd10, 16'd3, 2, 8'd0);
        request(FC_WRITE_MULTI, 16'd1990, 16'd11, 11, 8'd0);
        request(FC_WRITE_MULTI, 16'd0, 16'd0, 0, 8'd0);

        // unknown function codes, including the shortest frame
        request(8'h2B, 16'd0, 16'd1, 0, 8'd0);
        request(8'h00, 16'd0, 16'd1, 0, 8'd0);
        request(8'hFF, 16'd0, 16'd1, 0, 8'd0);
        begin_frame(sb.unit_id, 8'h41);
        seal_length();
        send_frame(1'b0);

        // dropped frames: protocol, length, unit, short header, short body
        build_request(sb.unit_id, FC_READ_HOLDING, 16'd0, 16'd1, 0, 8'd0);
        frame_q[2] = 8'h01;
        send_frame(1'b0);
        build_request(sb.unit_id, FC_READ_HOLDING, 16'd0, 16'd1, 0, 8'd0);
        frame_q[5] = frame_q[5] + 8'd1;
        send_frame(1'b0);
        build_request(sb.unit_id + 8'd1, FC_READ_HOLDING, 16'd0, 16'd1, 0, 8'd0);
        send_frame(1'b0);
        begin_frame(sb.unit_id, FC_READ_HOLDING);
        frame_q.pop_back();
        seal_length();
        send_frame(1'b0);
        begin_frame(sb.unit_id, FC_READ_HOLDING);
        put16(16'd0);
        frame_q.push_back(8'd1);
        seal_length();
        send_frame(1'b0);
        begin_frame(sb.unit_id, FC_WRITE_MULTI);
        put16(16'd0);
        put16(16'd1);
        seal_length();
        send_frame(1'b0);

        // overlong frame, then a good frame with trailing bytes
        begin_frame(sb.unit_id, FC_WRITE_SINGLE);
        put16(16'd1);
        put16(16'd2);
        repeat (250) frame_q.push_back($urandom_range(255));
        seal_length();
        send_frame(1'b0);
        begin_frame(sb.unit_id, FC_WRITE_SINGLE);
        put16(16'd3);
        put16(16'd4);
        repeat (8) frame_q.push_back($urandom_range(255));
        seal_length();
        send_frame(1'b0);

        // random phases over register settings, first one without idling
        run_phase(8'd0, 12'd4095, 60, 1'b1);
        run_phase(8'd255, 12'd1, 50, 1'b0);
        run_phase(8'h5A, 12'd0, 40, 1'b0);
        run_phase(8'd1, 12'd2048, 60, 1'b0);
        run_phase($urandom_range(255), $urandom_range(4095), 60, 1'b0);

        wait_idle(20);
        $display("run covered %0d input words over %0d register settings", sb.items_taken,
                 settings_done);
        $display("%0d result words checked, %0d mismatches", sb.replies_checked,
                 sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

>>> sim.f
src/mbtcp_pkg.sv
src/modbus_tcp_request_responder_top.sv
tb/tb_top.sv
